[sv/sds_pkg.sv]
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants of the SCAN disk scheduler
// Widths, register indexes and the structs that pass between the cell chain
// and the sweep controller.
// ----------------------------------------------------------------------------
package sds_pkg;

	// capacity of the request chain (1 to 63)
	localparam int MAX_REQUESTS = 32;
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);

	// field widths
	localparam int CYL_W   = 16;
	localparam int MOV_W   = 17;
	localparam int CCNT_W  = 17;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CYLINDER_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 1'd1;

	// what one cell shows its neighbors
	typedef struct packed {
		logic [CYL_W-1:0] m;     // sorted slot value
		logic             m_v;   // sorted slot holds a word
		logic             lt;    // incoming word sorts before this slot
		logic [CYL_W-1:0] a;     // stack slot value
		logic             a_v;   // stack slot holds a word
	} sds_link_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic ins;      // insert a request in sorted order
		logic m_shl;    // shift sorted row toward cell 0
		logic a_push;   // push onto stack row (cell 0 takes sorted head)
		logic a_pop;    // pop stack row toward cell 0
	} sds_ctl_t;

	// status of the head end of the chain
	typedef struct packed {
		logic [CYL_W-1:0] m;
		logic             m_v;
		logic [CYL_W-1:0] a;
		logic             a_v;
		logic             a1_v;  // a second stack entry exists
	} sds_head_t;

endpackage

[sv/sds_req_if.sv]
// ----------------------------------------------------------------------------
// sds_req_if: request channel
// Carries one cylinder request per word, the last of a batch marked.
// ----------------------------------------------------------------------------
interface sds_req_if import sds_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [CYL_W-1:0] request_cylinder;
	logic             final_request;

	modport source (output valid, output request_cylinder, output final_request,
		input ready);
	modport sink (input valid, input request_cylinder, input final_request,
		output ready);

endinterface

[sv/sds_visit_if.sv]
// ----------------------------------------------------------------------------
// sds_visit_if: visit channel
// Carries one visited cylinder per word with the running head movement.
// ----------------------------------------------------------------------------
interface sds_visit_if import sds_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [CYL_W-1:0] visited_cylinder;
	logic [MOV_W-1:0] movement_so_far;
	logic             end_of_path;

	modport source (output valid, output visited_cylinder, output movement_so_far,
		output end_of_path, input ready);
	modport sink (input valid, input visited_cylinder, input movement_so_far,
		input end_of_path, output ready);

endinterface

[sv/sds_cell.sv]
// ----------------------------------------------------------------------------
// sds_cell: one slot of the request chain
// Holds one slot of the ascending sorted row and one slot of the stack row
// used for the downward half of the sweep; trades words with its neighbors.
// ----------------------------------------------------------------------------
module sds_cell import sds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  sds_ctl_t         ctl,
	input  logic [CYL_W-1:0] ins_val,
	input  sds_link_t        left,
	input  sds_link_t        right,
	output sds_link_t        self
);

	logic [CYL_W-1:0] m_q;
	logic             m_v_q;
	logic [CYL_W-1:0] a_q;
	logic             a_v_q;
	logic             lt;

	// empty slot counts as larger than any request
	assign lt = !m_v_q || (ins_val < m_q);

	assign self.m   = m_q;
	assign self.m_v = m_v_q;
	assign self.lt  = lt;
	assign self.a   = a_q;
	assign self.a_v = a_v_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_q <= 1'b0;
			a_v_q <= 1'b0;
		end else begin
			if (ctl.ins && lt) begin
				m_v_q <= left.lt ? left.m_v : 1'b1;
			end else if (ctl.m_shl) begin
				m_v_q <= right.m_v;
			end
			if (ctl.a_push) begin
				a_v_q <= left.a_v;
			end else if (ctl.a_pop) begin
				a_v_q <= right.a_v;
			end
		end
	end

	// slot values
	always_ff @(posedge clk) begin
		if (ctl.ins && lt) begin
			m_q <= left.lt ? left.m : ins_val;
		end else if (ctl.m_shl) begin
			m_q <= right.m;
		end
		if (ctl.a_push) begin
			a_q <= left.a;
		end else if (ctl.a_pop) begin
			a_q <= right.a;
		end
	end

endmodule

[sv/sds_chain.sv]
// ----------------------------------------------------------------------------
// sds_chain: row of request cells
// Cell 0 is the head end; the sorted row grows toward the far end and the
// stack row is pushed and popped at cell 0.
// ----------------------------------------------------------------------------
module sds_chain import sds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  sds_ctl_t         ctl,
	input  logic [CYL_W-1:0] ins_val,
	output sds_head_t        hd
);

	sds_link_t link_w [MAX_REQUESTS];
	sds_link_t head_left;

	// cell 0 sees no smaller neighbor; its stack input is the sorted head
	always_comb begin
		head_left     = '0;
		head_left.a   = link_w[0].m;
		head_left.a_v = 1'b1;
	end

	for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
		sds_link_t left_w;
		sds_link_t right_w;

		if (i == 0) begin : g_first
			assign left_w = head_left;
		end else begin : g_mid
			assign left_w = link_w[i-1];
		end

		if (i == MAX_REQUESTS - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = link_w[i+1];
		end

		sds_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.ins_val (ins_val),
			.left    (left_w),
			.right   (right_w),
			.self    (link_w[i])
		);
	end

	// head status
	assign hd.m   = link_w[0].m;
	assign hd.m_v = link_w[0].m_v;
	assign hd.a   = link_w[0].a;
	assign hd.a_v = link_w[0].a_v;

	if (MAX_REQUESTS > 1) begin : g_a1
		assign hd.a1_v = link_w[1].a_v;
	end else begin : g_no_a1
		assign hd.a1_v = 1'b0;
	end

endmodule

[sv/scan_disk_scheduler.sv]
// ----------------------------------------------------------------------------
// scan_disk_scheduler: SCAN (elevator) order for a batch of cylinder requests
//
// Requests arrive on the req channel, one word per cylinder; the word with
// final_request set closes the batch. Each request is inserted in sorted
// order into a chain of MAX_REQUESTS cells in the cycle it is accepted, so
// req.ready stays high and one request is taken every cycle while collecting.
// Requests beyond the chain capacity are dropped; a dropped final word still
// starts the sweep. cylinder_count and start_position are written through
// the cfg port and are sampled when the final word is accepted.
// After the final word the block moves each request below the start
// cylinder onto the stack row, then sends one visit word per cycle while
// visit.ready allows: ascending from the start up to the top cylinder,
// then descending below the start. A batch of N requests gives up to N + 1
// visit words; the last one has end_of_path set. No request is taken during
// the sweep. The visit word sits in an output register: when visit.ready is
// low the sweep simply halts and resumes where it stopped; the next batch
// may begin while the last visit word still waits. Reset empties the chain
// and loads the register defaults (200 cylinders, start at 0).
// ----------------------------------------------------------------------------
module scan_disk_scheduler import sds_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sds_req_if.sink              req,
	sds_visit_if.source          visit
);

	typedef enum logic [1:0] {
		S_COLLECT,
		S_SPLIT,
		S_UP,
		S_DOWN
	} state_t;

	state_t           state_q;
	logic [CCNT_W-1:0] ccnt_q;
	logic [CYL_W-1:0] spos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CYL_W-1:0] top_q;
	logic [CYL_W-1:0] start_q;
	logic [CYL_W-1:0] head_q;
	logic [MOV_W-1:0] mov_q;
	logic             o_valid_q;
	logic [CYL_W-1:0] o_cyl_q;
	logic [MOV_W-1:0] o_mov_q;
	logic             o_last_q;

	sds_ctl_t         ctl;
	sds_head_t        hd;
	logic             req_acc;
	logic             has_room;
	logic             load;
	logic             split_go;
	logic [CYL_W-1:0] top_c;
	logic [CYL_W-1:0] start_c;
	logic             emit_v;
	logic [CYL_W-1:0] emit_cyl;
	logic             emit_last;
	logic [CYL_W-1:0] step_cyl;
	logic [MOV_W-1:0] mov_n;

	// handshakes
	assign req.ready = (state_q == S_COLLECT);
	assign req_acc   = req.valid && req.ready;
	assign has_room  = (cnt_q < CNT_W'(MAX_REQUESTS));
	assign load      = !o_valid_q || visit.ready;

	assign visit.valid            = o_valid_q;
	assign visit.visited_cylinder = o_cyl_q;
	assign visit.movement_so_far  = o_mov_q;
	assign visit.end_of_path      = o_last_q;

	// top cylinder and clamped start from the current registers
	always_comb begin
		if (ccnt_q == '0) begin
			top_c = '0;
		end else if (ccnt_q[CCNT_W-1]) begin
			top_c = '1;
		end else begin
			top_c = ccnt_q[CYL_W-1:0] - CYL_W'(1);
		end
		start_c = (spos_q > top_c) ? top_c : spos_q;
	end

	// requests below the start go onto the stack row
	assign split_go = (state_q == S_SPLIT) && hd.m_v && (hd.m < start_q);

	// chain commands
	always_comb begin
		ctl        = '0;
		ctl.ins    = req_acc && has_room;
		ctl.m_shl  = split_go || ((state_q == S_UP) && load && hd.m_v);
		ctl.a_push = split_go;
		ctl.a_pop  = (state_q == S_DOWN) && load;
	end

	sds_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.ins_val (req.request_cylinder),
		.hd      (hd)
	);

	// next visit word
	always_comb begin
		emit_v    = 1'b0;
		emit_cyl  = hd.a;
		emit_last = 1'b0;
		case (state_q)
			S_UP: begin
				emit_v = load;
				if (hd.m_v) begin
					emit_cyl = (hd.m > top_q) ? top_q : hd.m;
				end else begin
					emit_cyl  = top_q;
					emit_last = !hd.a_v;
				end
			end
			S_DOWN: begin
				emit_v    = load;
				emit_cyl  = hd.a;
				emit_last = !hd.a1_v;
			end
			default: begin
				emit_v = 1'b0;
			end
		endcase
		step_cyl = (emit_cyl >= head_q) ? (emit_cyl - head_q) : (head_q - emit_cyl);
		mov_n    = mov_q + MOV_W'(step_cyl);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccnt_q <= CCNT_W'(200);
			spos_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CYLINDER_COUNT: ccnt_q <= cfg_data[CCNT_W-1:0];
				CFG_START_POSITION: spos_q <= cfg_data[CYL_W-1:0];
				default: ;
			endcase
		end
	end

	// sweep control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_COLLECT;
			cnt_q     <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (load) begin
				o_valid_q <= emit_v;
			end
			unique case (state_q)
				S_COLLECT: begin
					if (req_acc && req.final_request) begin
						cnt_q   <= '0;
						state_q <= S_SPLIT;
					end else if (req_acc && has_room) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_SPLIT: begin
					if (!split_go) begin
						state_q <= S_UP;
					end
				end
				S_UP: begin
					if (load && !hd.m_v) begin
						state_q <= hd.a_v ? S_DOWN : S_COLLECT;
					end
				end
				S_DOWN: begin
					if (load && !hd.a1_v) begin
						state_q <= S_COLLECT;
					end
				end
				default: state_q <= S_COLLECT;
			endcase
		end
	end

	// sweep payload: head, movement and output word
	always_ff @(posedge clk) begin
		if (req_acc && req.final_request) begin
			top_q   <= top_c;
			start_q <= start_c;
			head_q  <= start_c;
			mov_q   <= '0;
		end else if (emit_v) begin
			head_q <= emit_cyl;
			mov_q  <= mov_n;
		end
		if (emit_v) begin
			o_cyl_q  <= emit_cyl;
			o_mov_q  <= mov_n;
			o_last_q <= emit_last;
		end
	end

	// the top cylinder is sent once the sorted row runs dry
	a_top_visit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP && load && !hd.m_v) |=> (visit.visited_cylinder == $past(top_q)))
		else $error("top cylinder not sent at end of upward pass");

	// stack entries are all below the start
	a_stack_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DOWN && hd.a_v) |-> (hd.a < start_q))
		else $error("stack holds a cylinder at or above the start");

	// the last word of a sweep returns the block to collecting
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_v && emit_last) |=> (state_q == S_COLLECT))
		else $error("sweep continues past end of path");

	// no requests taken while a sweep is running
	a_no_req_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_COLLECT) |-> !ctl.ins)
		else $error("request inserted during sweep");

endmodule

[tb/sv/scan_disk_scheduler_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scan_disk_scheduler_test: self-checking bench for the SCAN disk scheduler
// A short table of directed batches comes first. Some rows carry visit words
// typed in by hand, and the rest are checked against the bench's own sweep
// planner. Random batches follow, with random register settings before some of them.
// Both channels idle at random. Every accepted visit word is compared with
// the oldest planned one.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_test;
	import sds_pkg::*;

	localparam int RANDOM_ITEMS = 500;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int DRAIN_LIMIT  = 200000;
	localparam int IDLE_SETTLE  = 4;
	localparam int TAIL_CYCLES  = 40;
	localparam int SHOWN_ERRORS = 10;

	typedef struct packed {
		logic [CYL_W-1:0] cyl;
		logic [MOV_W-1:0] mov;
		logic             eop;
	} visit_t;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic [CYL_W-1:0]     cyl;
		logic                 fin;
		int                   n_typed;
		visit_t [2:0]         typed;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	sds_req_if   req_ch ();
	sds_visit_if visit_ch ();

	scan_disk_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.visit     (visit_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// planner state: registers, held batch, head and travel
	logic [CYL_W-1:0]  held_req [MAX_REQUESTS];
	int                held_count;
	logic [CCNT_W-1:0] cyl_count_reg;
	logic [CYL_W-1:0]  start_reg;
	logic [CYL_W-1:0]  head_cyl;
	logic [17:0]       travel_total;

	visit_t sweep_plan [$];
	visit_t pending_visits [$];
	row_t   rows [$];

	int mismatches  = 0;
	int cycle_count = 0;

	function automatic visit_t vw(int cyl, int mov, bit eop);
		visit_t v;
		v.cyl = cyl[CYL_W-1:0];
		v.mov = mov[MOV_W-1:0];
		v.eop = eop;
		return v;
	endfunction

	function automatic logic [CYL_W-1:0] top_of(logic [CCNT_W-1:0] c);
		logic [CCNT_W-1:0] t;
		if (c == '0) begin
			t = '0;
		end else if (c > 17'd65536) begin
			t = 17'd65535;
		end else begin
			t = c - 17'd1;
		end
		return t[CYL_W-1:0];
	endfunction

	// one head move: add distance, record the visit word
	function automatic void visit_to(logic [CYL_W-1:0] cyl, logic eop);
		logic [CYL_W-1:0] d;
		visit_t v;
		d = (cyl > head_cyl) ? cyl - head_cyl : head_cyl - cyl;
		travel_total = travel_total + 18'(d);
		head_cyl = cyl;
		v.cyl = cyl;
		v.mov = travel_total[MOV_W-1:0];
		v.eop = eop;
		sweep_plan.push_back(v);
	endfunction

	// store a request; on the last one plan the whole sweep
	function automatic void take_request(logic [CYL_W-1:0] cyl, logic fin);
		logic [CYL_W-1:0] list [MAX_REQUESTS+1];
		logic [CYL_W-1:0] top, start, v;
		int n, i, j;
		sweep_plan.delete();
		if (held_count < MAX_REQUESTS) begin
			held_req[held_count] = cyl;
			held_count++;
		end
		if (!fin) return;
		top = top_of(cyl_count_reg);
		start = (start_reg > top) ? top : start_reg;
		n = held_count;
		for (i = 0; i < n; i++) list[i] = (held_req[i] > top) ? top : held_req[i];
		list[n] = top;
		n++;
		// ascending insertion sort
		for (i = 1; i < n; i++) begin
			v = list[i];
			j = i;
			while (j > 0 && list[j-1] > v) begin
				list[j] = list[j-1];
				j--;
			end
			list[j] = v;
		end
		j = 0;
		while (j < n && list[j] < start) j++;
		head_cyl = start;
		travel_total = '0;
		// upward pass, then back down below the start
		for (i = j; i < n; i++) visit_to(list[i], (i == n - 1) && (j == 0));
		for (i = j; i > 0; i--) visit_to(list[i-1], i == 1);
		held_count = 0;
		travel_total = '0;
	endfunction

	function automatic void queue_plan();
		foreach (sweep_plan[i]) pending_visits.push_back(sweep_plan[i]);
	endfunction

	// directed table builders
	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int data);
		row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data[CFG_W-1:0];
		r.cyl = '0;
		r.fin = 1'b0;
		r.n_typed = 0;
		r.typed = '0;
		rows.push_back(r);
	endfunction

	function automatic void add_req(int cyl, bit fin, int n_typed = 0,
		visit_t t0 = '0, visit_t t1 = '0, visit_t t2 = '0);
		row_t r;
		r.kind = ROW_REQ;
		r.idx = CFG_CYLINDER_COUNT;
		r.data = '0;
		r.cyl = cyl[CYL_W-1:0];
		r.fin = fin;
		r.n_typed = n_typed;
		r.typed[0] = t0;
		r.typed[1] = t1;
		r.typed[2] = t2;
		rows.push_back(r);
	endfunction

	// mostly short gaps, a few long ones, none in a burst
	function automatic int pick_gap(bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CYL_W-1:0] pick_cylinder(logic [CYL_W-1:0] prev);
		int top, r;
		top = int'(top_of(cyl_count_reg));
		r = $urandom_range(0, 99);
		if (r < 35) return CYL_W'($urandom_range(0, 65535));
		if (r < 60) return CYL_W'($urandom_range(0, top));
		if (r < 70) return start_reg;
		if (r < 78) return CYL_W'(top);
		if (r < 85) return (top < 65535) ? CYL_W'($urandom_range(top + 1, 65535)) : 16'hFFFF;
		if (r < 93) return prev;
		return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CYLINDER_COUNT) begin
			cyl_count_reg = data[CCNT_W-1:0];
		end else begin
			start_reg = data[CYL_W-1:0];
		end
	endtask

	// hold off requests until every planned visit word has arrived
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_visits.size() != 0);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic send_req(logic [CYL_W-1:0] cyl, logic fin, int gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.request_cylinder <= cyl;
		req_ch.final_request <= fin;
		do @(posedge clk); while (!req_ch.ready);
		take_request(cyl, fin);
	endtask

	// new register values, extremes included
	task automatic retune();
		int mode, top;
		logic [CFG_W-1:0] val;
		mode = $urandom_range(0, 2);
		if (mode != 1) begin
			case ($urandom_range(0, 7))
				0: val = 17'd0;
				1: val = 17'd1;
				2: val = CFG_W'($urandom_range(2, 16));
				3: val = 17'd200;
				4: val = CFG_W'($urandom_range(17, 4096));
				5: val = CFG_W'($urandom_range(1, 65536));
				6: val = 17'd65536;
				default: val = CFG_W'($urandom_range(65537, 131071));
			endcase
			cfg_write(CFG_CYLINDER_COUNT, val);
		end
		if (mode != 0) begin
			top = int'(top_of(cyl_count_reg));
			case ($urandom_range(0, 4))
				0: val = 17'd0;
				1: val = CFG_W'(top);
				2: val = CFG_W'($urandom_range(0, top));
				3: val = CFG_W'($urandom_range(0, 65535));
				default: val = 17'd65535;
			endcase
			cfg_write(CFG_START_POSITION, val);
		end
	endtask

	// visit side: random stalls with calm stretches
	initial begin
		int hold, calm, r;
		hold = 0;
		calm = 0;
		visit_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				visit_ch.ready <= 1'b0;
			end else begin
				visit_ch.ready <= 1'b1;
				r = $urandom_range(0, 99);
				if (calm > 0) begin
					calm--;
				end else if (r < 3) begin
					calm = $urandom_range(50, 200);
				end else if (r < 25) begin
					hold = $urandom_range(1, 3);
				end else if (r < 29) begin
					hold = $urandom_range(10, 40);
				end
			end
		end
	end

	// compare each accepted visit word with the oldest planned one
	visit_t got_visit, want_visit;
	always @(posedge clk) begin
		if (arst_n && visit_ch.valid && visit_ch.ready) begin
			got_visit.cyl = visit_ch.visited_cylinder;
			got_visit.mov = visit_ch.movement_so_far;
			got_visit.eop = visit_ch.end_of_path;
			if (pending_visits.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("unexpected visit word: cyl=%0d mov=%0d end=%0b",
						got_visit.cyl, got_visit.mov, got_visit.eop);
			end else begin
				want_visit = pending_visits.pop_front();
				if (got_visit !== want_visit) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("visit mismatch: exp cyl=%0d mov=%0d end=%0b, got cyl=%0d mov=%0d end=%0b",
							want_visit.cyl, want_visit.mov, want_visit.eop,
							got_visit.cyl, got_visit.mov, got_visit.eop);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int r, k, n_batch, random_sent, drain;
		bit burst;
		logic [CYL_W-1:0] c;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CYLINDER_COUNT;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.request_cylinder <= '0;
		req_ch.final_request <= 1'b0;
		cyl_count_reg = 17'd200;
		start_reg = '0;
		held_count = 0;
		head_cyl = '0;
		travel_total = '0;

		// defaults: 200 cylinders, start at 0
		add_req(50, 1, 2, vw(50, 50, 0), vw(199, 199, 1));
		add_req(0, 1, 2, vw(0, 0, 0), vw(199, 199, 1));
		// request past the top is clamped
		add_req(65535, 1, 2, vw(199, 199, 0), vw(199, 199, 1));
		// both directions around a middle start, one equal to the start
		add_cfg(CFG_START_POSITION, 100);
		add_req(150, 0);
		add_req(20, 0);
		add_req(100, 0);
		add_req(180, 1);
		// zero cylinders: top is 0, start clamped down
		add_cfg(CFG_CYLINDER_COUNT, 0);
		add_req(5, 1, 2, vw(0, 0, 0), vw(0, 0, 1));
		// widest setting, start at the top
		add_cfg(CFG_CYLINDER_COUNT, 131071);
		add_cfg(CFG_START_POSITION, 65535);
		add_req(0, 1, 2, vw(65535, 0, 0), vw(0, 65535, 1));
		// longest travel
		add_cfg(CFG_START_POSITION, 1);
		add_req(0, 1, 2, vw(65535, 65534, 0), vw(0, 131069, 1));
		// one cylinder only
		add_cfg(CFG_CYLINDER_COUNT, 1);
		add_cfg(CFG_START_POSITION, 0);
		add_req(65535, 0);
		add_req(0, 1, 3, vw(0, 0, 0), vw(0, 0, 0), vw(0, 0, 1));
		add_cfg(CFG_CYLINDER_COUNT, 65536);
		add_req(65535, 0);
		add_req(0, 0);
		add_req(32768, 1);
		add_cfg(CFG_CYLINDER_COUNT, 65537);
		add_req(12345, 1);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				wait_idle();
				cfg_write(rows[i].idx, rows[i].data);
			end else begin
				send_req(rows[i].cyl, rows[i].fin, pick_gap(0));
				if (rows[i].n_typed > 0) begin
					for (k = 0; k < rows[i].n_typed; k++)
						pending_visits.push_back(rows[i].typed[k]);
				end else begin
					queue_plan();
				end
			end
		end

		// random batches; some overfill the store
		random_sent = 0;
		c = '0;
		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				retune();
			end
			r = $urandom_range(0, 99);
			n_batch = (r < 10) ? $urandom_range(30, 40) : $urandom_range(1, 8);
			burst = ($urandom_range(0, 4) == 0);
			for (k = 0; k < n_batch; k++) begin
				c = pick_cylinder(c);
				send_req(c, k == n_batch - 1, pick_gap(burst));
				queue_plan();
				random_sent++;
			end
		end

		// drain
		req_ch.valid <= 1'b0;
		drain = 0;
		while (pending_visits.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_visits.size() != 0) begin
			mismatches += pending_visits.size();
			$display("%0d planned visit words never arrived", pending_visits.size());
		end
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[files.f]
sv/sds_pkg.sv
sv/sds_req_if.sv
sv/sds_visit_if.sv
sv/sds_cell.sv
sv/sds_chain.sv
sv/scan_disk_scheduler.sv
tb/sv/scan_disk_scheduler_test.sv
